// ===== rtl/core/sicrd_pkg.sv =====
package sicrd_pkg;

  // Field and register widths.
  localparam int unsigned ValueW      = 32;
  localparam int unsigned SymW        = 8;
  localparam int unsigned CountW      = 5;
  localparam int unsigned WordW       = 64;
  localparam int unsigned DigitW      = 4;

  // The largest radix the symbol table may define, and the byte slots held.
  localparam int unsigned MaxSymbols  = 16;
  localparam int unsigned SymbolSlots = 16;

  // The digit stack holds a full binary run of a 32-bit magnitude.
  localparam int unsigned StackDepth  = 32;
  localparam int unsigned StackAw     = $clog2(StackDepth);
  localparam int unsigned DepthW      = $clog2(StackDepth + 1);

  // The divider retires this many quotient bits per cycle.
  localparam int unsigned BitsPerStep = 8;
  localparam int unsigned DivSteps    = ValueW / BitsPerStep;
  localparam int unsigned StepW       = $clog2(DivSteps);

  // Register indices of the configuration port.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegSymbolCount = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSymbolsLow  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegSymbolsHigh = 2'd2;

  // Reset contents: radix ten with the decimal digit characters.
  localparam logic [CountW-1:0] RstSymbolCount = 5'd10;
  localparam logic [WordW-1:0]  RstSymbolsLow  = 64'h3736_3534_3332_3130;
  localparam logic [WordW-1:0]  RstSymbolsHigh = 64'h0000_0000_0000_3938;

  // Characters that may not appear in the symbol set; the minus also marks
  // a negative value.
  localparam logic [SymW-1:0] ChPlus  = 8'h2B;
  localparam logic [SymW-1:0] ChMinus = 8'h2D;

  typedef enum logic [2:0] {
    StIdle,
    StCheck,
    StDiv,
    StSign,
    StEmit
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic div_step;
    logic push;
    logic emit_sign;
    logic emit_digit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic set_valid;
    logic quo_zero;
    logic neg;
    logic last_digit;
  } dp_stat_t;

  // Picks the symbol byte for one digit value.
  function automatic logic [SymW-1:0] symbol_at(input logic [WordW-1:0]  lo,
                                                input logic [WordW-1:0]  hi,
                                                input logic [DigitW-1:0] idx);
    logic [WordW-1:0] word;
    word = idx[DigitW-1] ? hi : lo;
    return word[idx[DigitW-2:0]*SymW +: SymW];
  endfunction

endpackage

// ===== rtl/core/signed_int_to_custom_radix_digits_unit.sv =====
// Writes a signed 32-bit value as a run of character bytes in the radix that
// the configured symbol table defines, most significant digit first, with a
// leading minus byte for a negative value; the most negative value is written
// correctly. A request is taken when start_i is high while busy_o is low.
// Each character appears on symbol_o for exactly one cycle with strobe_o high,
// and last_o marks the final character of the run; the receiver cannot stall
// the block, so it must take every strobed character. If the symbol set is
// invalid (fewer than two symbols, more than sixteen, a plus or minus sign
// among them, or a repeated symbol) the request produces no characters at
// all and busy_o drops again after the check. For a valid set the block
// first checks the symbol set; each digit then comes from the shared long
// divider, which retires eight quotient bits a cycle against the radix;
// a negative value then emits its minus byte, and each digit leaves the
// digit stack as one character.
// Configuration may only be written while busy_o is low and no characters are
// still due.
module signed_int_to_custom_radix_digits_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic signed [sicrd_pkg::ValueW-1:0]  value_i,
  input  logic                                 cfg_we_i,
  input  logic        [sicrd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic        [sicrd_pkg::WordW-1:0]   cfg_data_i,
  output logic                                 strobe_o,
  output logic        [sicrd_pkg::SymW-1:0]    symbol_o,
  output logic                                 last_o
);

  logic [sicrd_pkg::CountW-1:0] symbol_count_q;
  logic [sicrd_pkg::WordW-1:0]  symbols_low_q;
  logic [sicrd_pkg::WordW-1:0]  symbols_high_q;
  sicrd_pkg::dp_cmd_t           cmd;
  sicrd_pkg::dp_stat_t          stat;

  // Configuration registers. A write to an unused index is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      symbol_count_q <= sicrd_pkg::RstSymbolCount;
      symbols_low_q  <= sicrd_pkg::RstSymbolsLow;
      symbols_high_q <= sicrd_pkg::RstSymbolsHigh;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sicrd_pkg::RegSymbolCount: begin
          symbol_count_q <= cfg_data_i[sicrd_pkg::CountW-1:0];
        end
        sicrd_pkg::RegSymbolsLow: begin
          symbols_low_q <= cfg_data_i;
        end
        sicrd_pkg::RegSymbolsHigh: begin
          symbols_high_q <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  // The controller sequences check, division and output; the datapath holds
  // the magnitude, the divider, the digit stack and the output register.
  sicrd_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  sicrd_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .value_i        (value_i),
    .symbol_count_i (symbol_count_q),
    .symbols_low_i  (symbols_low_q),
    .symbols_high_i (symbols_high_q),
    .symbol_o       (symbol_o),
    .last_o         (last_o),
    .strobe_o       (strobe_o)
  );

  // A character is only ever produced by a request in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(busy_o))
    else $error("character strobed without a request in progress");

  // The final character of a run coincides with the block falling idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && last_o |-> !busy_o)
    else $error("block still busy after the final character");

  // Any character before the final one leaves the block busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_o |-> busy_o)
    else $error("run ended without a final character");

  // An accepted request always occupies the block in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted request did not start");

endmodule

// ===== rtl/core/sicrd_ctrl.sv =====
module sicrd_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  sicrd_pkg::dp_stat_t stat_i,
  output sicrd_pkg::dp_cmd_t  cmd_o,
  output logic               busy_o
);

  sicrd_pkg::state_e state_q, state_d;
  logic [sicrd_pkg::StepW-1:0] step_q, step_d;
  logic                        div_last;

  assign div_last = (step_q == sicrd_pkg::StepW'(sicrd_pkg::DivSteps - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sicrd_pkg::StIdle;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    step_d  = '0;
    case (state_q)
      sicrd_pkg::StIdle: begin
        if (start_i) begin
          state_d = sicrd_pkg::StCheck;
        end
      end
      sicrd_pkg::StCheck: begin
        state_d = stat_i.set_valid ? sicrd_pkg::StDiv : sicrd_pkg::StIdle;
      end
      sicrd_pkg::StDiv: begin
        step_d = step_q + 1'b1;
        if (div_last && stat_i.quo_zero) begin
          state_d = stat_i.neg ? sicrd_pkg::StSign : sicrd_pkg::StEmit;
        end
      end
      sicrd_pkg::StSign: begin
        state_d = sicrd_pkg::StEmit;
      end
      sicrd_pkg::StEmit: begin
        if (stat_i.last_digit) begin
          state_d = sicrd_pkg::StIdle;
        end
      end
      default: begin
        state_d = sicrd_pkg::StIdle;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      sicrd_pkg::StIdle: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      sicrd_pkg::StCheck: begin
      end
      sicrd_pkg::StDiv: begin
        cmd_o.div_step = 1'b1;
        cmd_o.push     = div_last;
      end
      sicrd_pkg::StSign: begin
        cmd_o.emit_sign = 1'b1;
      end
      sicrd_pkg::StEmit: begin
        cmd_o.emit_digit = 1'b1;
      end
      default: begin
        busy_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/core/sicrd_datapath.sv =====
module sicrd_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  sicrd_pkg::dp_cmd_t                     cmd_i,
  output sicrd_pkg::dp_stat_t                    stat_o,
  input  logic signed [sicrd_pkg::ValueW-1:0]   value_i,
  input  logic        [sicrd_pkg::CountW-1:0]   symbol_count_i,
  input  logic        [sicrd_pkg::WordW-1:0]    symbols_low_i,
  input  logic        [sicrd_pkg::WordW-1:0]    symbols_high_i,
  output logic        [sicrd_pkg::SymW-1:0]     symbol_o,
  output logic                                  last_o,
  output logic                                  strobe_o
);

  logic [sicrd_pkg::ValueW-1:0]   raw;
  logic [sicrd_pkg::ValueW-1:0]   mag_q, mag_d;
  logic [sicrd_pkg::DigitW-1:0]   rem_q, rem_d;
  logic                           neg_q;
  logic [sicrd_pkg::DepthW-1:0]   cnt_q;
  logic [sicrd_pkg::DepthW-1:0]   top_idx;
  logic [sicrd_pkg::DigitW-1:0]   stack_q [sicrd_pkg::StackDepth];
  logic [sicrd_pkg::BitsPerStep-1:0] qbyte;
  logic [sicrd_pkg::DigitW-1:0]   rem_step;
  logic [sicrd_pkg::DigitW:0]     trial;
  logic                           set_valid;
  logic [sicrd_pkg::SymW-1:0]     sym_a;
  logic [sicrd_pkg::SymW-1:0]     symbol_q, symbol_d;
  logic                           last_q, last_d;
  logic                           strobe_q;

  assign raw = value_i;

  // Symbol set check: radix in range, no sign characters, no repeats.
  always_comb begin
    set_valid = (symbol_count_i >= sicrd_pkg::CountW'(2)) &&
                (symbol_count_i <= sicrd_pkg::CountW'(sicrd_pkg::MaxSymbols)) &&
                (symbol_count_i <= sicrd_pkg::CountW'(sicrd_pkg::SymbolSlots));
    for (int i = 0; i < sicrd_pkg::SymbolSlots; i++) begin
      sym_a = sicrd_pkg::symbol_at(symbols_low_i, symbols_high_i,
                                   sicrd_pkg::DigitW'(i));
      if (sicrd_pkg::CountW'(i) < symbol_count_i) begin
        if (sym_a == sicrd_pkg::ChPlus || sym_a == sicrd_pkg::ChMinus) begin
          set_valid = 1'b0;
        end
        for (int j = i + 1; j < sicrd_pkg::SymbolSlots; j++) begin
          if ((sicrd_pkg::CountW'(j) < symbol_count_i) &&
              (sym_a == sicrd_pkg::symbol_at(symbols_low_i, symbols_high_i,
                                             sicrd_pkg::DigitW'(j)))) begin
            set_valid = 1'b0;
          end
        end
      end
    end
  end

  // Eight restoring long-division steps on the top byte of the magnitude.
  always_comb begin
    rem_step = rem_q;
    qbyte    = '0;
    trial    = '0;
    for (int b = 0; b < sicrd_pkg::BitsPerStep; b++) begin
      trial = {rem_step, mag_q[sicrd_pkg::ValueW-1-b]};
      if (trial >= symbol_count_i) begin
        trial                                = trial - symbol_count_i;
        qbyte[sicrd_pkg::BitsPerStep-1-b]    = 1'b1;
      end
      rem_step = trial[sicrd_pkg::DigitW-1:0];
    end
  end

  always_comb begin
    mag_d = mag_q;
    rem_d = rem_q;
    if (cmd_i.load) begin
      mag_d = raw[sicrd_pkg::ValueW-1] ? (sicrd_pkg::ValueW'(0) - raw) : raw;
      rem_d = '0;
    end else if (cmd_i.div_step) begin
      mag_d = {mag_q[sicrd_pkg::ValueW-sicrd_pkg::BitsPerStep-1:0], qbyte};
      rem_d = cmd_i.push ? '0 : rem_step;
    end
  end

  assign top_idx = cnt_q - 1'b1;

  always_comb begin
    symbol_d = symbol_q;
    last_d   = last_q;
    if (cmd_i.emit_sign) begin
      symbol_d = sicrd_pkg::ChMinus;
      last_d   = 1'b0;
    end else if (cmd_i.emit_digit) begin
      symbol_d = sicrd_pkg::symbol_at(symbols_low_i, symbols_high_i,
                                      stack_q[top_idx[sicrd_pkg::StackAw-1:0]]);
      last_d   = (cnt_q == sicrd_pkg::DepthW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q    <= mag_d;
    rem_q    <= rem_d;
    symbol_q <= symbol_d;
    last_q   <= last_d;
    if (cmd_i.load) begin
      neg_q <= raw[sicrd_pkg::ValueW-1];
    end
    if (cmd_i.push) begin
      stack_q[cnt_q[sicrd_pkg::StackAw-1:0]] <= rem_step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.emit_sign | cmd_i.emit_digit;
      if (cmd_i.load) begin
        cnt_q <= '0;
      end else if (cmd_i.push) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (cmd_i.emit_digit) begin
        cnt_q <= top_idx;
      end
    end
  end

  assign stat_o.set_valid  = set_valid;
  assign stat_o.quo_zero   = ({mag_q[sicrd_pkg::ValueW-sicrd_pkg::BitsPerStep-1:0], qbyte}
                              == '0);
  assign stat_o.neg        = neg_q;
  assign stat_o.last_digit = (cnt_q == sicrd_pkg::DepthW'(1));

  assign symbol_o = symbol_q;
  assign last_o   = last_q;
  assign strobe_o = strobe_q;

endmodule
